FILE: rtl/wapc_pkg.sv
// Shared types and constants for the window anti-pinch controller.
// No dependencies; imported by wapc_step, window_anti_pinch_controller and the testbench.
package wapc_pkg;

  // Window mode, also sent out as the 3-bit window_mode field
  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_UP      = 3'd1,
    MODE_DOWN    = 3'd2,
    MODE_REVERSE = 3'd3,
    MODE_BLOCKED = 3'd4
  } mode_t;

  // Switch commands; codes 5..7 act as no command
  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_UP      = 3'd1;
  localparam logic [2:0] OP_AUTO_UP = 3'd2;
  localparam logic [2:0] OP_DOWN    = 3'd3;
  localparam logic [2:0] OP_STOP    = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_PINCH_LIMIT = 3'd0;
  localparam logic [2:0] REG_DEBOUNCE    = 3'd1;
  localparam logic [2:0] REG_REV_TRAVEL  = 3'd2;
  localparam logic [2:0] REG_SOFT_ZONE   = 3'd3;
  localparam logic [2:0] REG_OPEN_LIMIT  = 3'd4;

  localparam int OPCODE_W = 3;
  localparam int DRIVE_W  = 7;
  localparam int MODE_W   = 3;
  localparam int LIMIT_W  = 16;
  localparam int DEB_W    = 4;
  localparam int TRAVEL_W = 8;
  localparam int ZONE_W   = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [DRIVE_W-1:0] DRIVE_ON  = 7'd100;
  localparam logic [DRIVE_W-1:0] DRIVE_OFF = 7'd0;

  // Reset values of the configuration registers
  localparam logic [LIMIT_W-1:0]  RST_PINCH_LIMIT = 16'd8000;
  localparam logic [DEB_W-1:0]    RST_DEBOUNCE    = 4'd3;
  localparam logic [TRAVEL_W-1:0] RST_REV_TRAVEL  = 8'd60;
  localparam logic [ZONE_W-1:0]   RST_SOFT_ZONE   = 12'd30;
  localparam logic [ZONE_W-1:0]   RST_OPEN_LIMIT  = 12'd1000;

  typedef struct packed {
    logic [LIMIT_W-1:0]  pinch_limit;
    logic [DEB_W-1:0]    debounce;
    logic [TRAVEL_W-1:0] rev_travel;
    logic [ZONE_W-1:0]   soft_zone;
    logic [ZONE_W-1:0]   open_limit;
  } cfg_regs_t;

  // Mode and debounce count carried between ticks
  typedef struct packed {
    mode_t            mode;
    logic [DEB_W-1:0] pinch_count;
  } ctrl_state_t;

endpackage

FILE: rtl/wapc_step.sv
// One control tick of the anti-pinch mode machine, purely combinational.
// Depends on wapc_pkg (mode_t, ctrl_state_t, cfg_regs_t, opcodes).
module wapc_step #(
  parameter int POSITION_BITS = 12,
  parameter int CURRENT_BITS  = 16
) (
  input  wapc_pkg::cfg_regs_t          cfg,
  input  logic [wapc_pkg::OPCODE_W-1:0] opcode,
  input  logic [POSITION_BITS-1:0]     position,
  input  logic [CURRENT_BITS-1:0]      motor_cur,
  input  wapc_pkg::ctrl_state_t        state,
  input  logic [POSITION_BITS:0]       goal,
  output wapc_pkg::ctrl_state_t        state_nxt,
  output logic [POSITION_BITS:0]       goal_nxt,
  output logic [wapc_pkg::DRIVE_W-1:0] drive_up,
  output logic [wapc_pkg::DRIVE_W-1:0] drive_down
);
  import wapc_pkg::*;

  // Compare width that covers both the position and the 12-bit settings
  localparam int CMP_W  = (POSITION_BITS > ZONE_W) ? POSITION_BITS : ZONE_W;
  localparam int GOAL_W = POSITION_BITS + 1;
  localparam int SUM_W  = GOAL_W + 1;

  logic [CMP_W-1:0]   pos_cmp;
  logic [LIMIT_W-1:0] cur_cmp;
  logic [DEB_W-1:0]   need;
  logic               in_zone;
  logic               over_limit;
  logic [DEB_W-1:0]   count_chk;
  logic               pinch;
  logic [SUM_W-1:0]   goal_sum;
  logic [GOAL_W-1:0]  goal_sat;

  assign pos_cmp    = CMP_W'(position);
  assign cur_cmp    = LIMIT_W'(motor_cur);
  assign need       = (cfg.debounce == '0) ? DEB_W'(1) : cfg.debounce;
  assign in_zone    = pos_cmp <= CMP_W'(cfg.soft_zone);
  assign over_limit = cur_cmp > cfg.pinch_limit;

  // Debounce count: saturates at need, cleared in the zone or at or below limit
  always_comb begin
    if (in_zone || !over_limit) begin
      count_chk = '0;
    end else if (state.pinch_count < need) begin
      count_chk = state.pinch_count + DEB_W'(1);
    end else begin
      count_chk = state.pinch_count;
    end
  end

  assign pinch = !in_zone && (count_chk >= need);

  // Reverse goal, saturating instead of wrapping
  assign goal_sum = SUM_W'(position) + SUM_W'(cfg.rev_travel);
  assign goal_sat = goal_sum[SUM_W-1] ? {GOAL_W{1'b1}} : goal_sum[GOAL_W-1:0];

  always_comb begin
    state_nxt  = state;
    goal_nxt   = goal;
    drive_up   = DRIVE_OFF;
    drive_down = DRIVE_OFF;
    case (state.mode)
      MODE_IDLE: begin
        if (opcode == OP_UP || opcode == OP_AUTO_UP) begin
          state_nxt.mode = MODE_UP;
        end else if (opcode == OP_DOWN) begin
          state_nxt.mode = MODE_DOWN;
        end
      end
      MODE_UP: begin
        state_nxt.pinch_count = count_chk;
        if (pinch) begin
          goal_nxt       = goal_sat;
          state_nxt.mode = MODE_REVERSE;
          drive_down     = DRIVE_ON;
        end else if (position == '0 || opcode == OP_STOP) begin
          state_nxt.mode = MODE_IDLE;
        end else begin
          drive_up = DRIVE_ON;
        end
      end
      MODE_REVERSE: begin
        if (GOAL_W'(position) >= goal) begin
          state_nxt.mode = MODE_BLOCKED;
        end else begin
          drive_down = DRIVE_ON;
        end
      end
      MODE_DOWN: begin
        if (opcode == OP_STOP || pos_cmp >= CMP_W'(cfg.open_limit)) begin
          state_nxt.mode = MODE_IDLE;
        end else begin
          drive_down = DRIVE_ON;
        end
      end
      MODE_BLOCKED: begin
        if (opcode == OP_DOWN) begin
          state_nxt.mode = MODE_DOWN;
        end
      end
      default: begin
        state_nxt.mode = MODE_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/window_anti_pinch_controller.sv
// Top level of the power window anti-pinch controller.
// Depends on wapc_pkg and wapc_step.
//
//  channel | direction | payload                                   | handshake
//  --------+-----------+-------------------------------------------+-------------------
//  in_     | slave     | tdata: opcode, position, motor_cur        | in_tvalid/in_tready
//  out_    | master    | tdata: drive_up, drive_down, window_mode  | out_tvalid/out_tready
//  cfg_    | slave     | cfg_index, cfg_data                       | cfg_valid/cfg_ready
//
// Each request goes through two registers: an input register and a result
// register, with one tick of the mode machine between them. out_tvalid rises
// once the request has moved into the result register; one request is taken
// every cycle while the result register is free or being drained.
// Reset (rst_n low, synchronous) empties both stages, sets mode idle, clears
// the debounce count and the reverse goal and loads the register defaults.
// A stall on out_tready holds the result register; the input register still
// takes a request while the result register is empty or being drained.
// Configuration writes are always accepted and take effect at once.
module window_anti_pinch_controller #(
  parameter int POSITION_BITS = 12,
  parameter int CURRENT_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata, low bit up: opcode[3], position[POSITION_BITS],
  // motor_cur[CURRENT_BITS], zero fill to whole bytes
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [((wapc_pkg::OPCODE_W + POSITION_BITS + CURRENT_BITS + 7) / 8) * 8 - 1:0]
                                          in_tdata,
  // out_tdata, low bit up: drive_up[7], drive_down[7], window_mode[3], zero fill
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [23:0]                     out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wapc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wapc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wapc_pkg::*;

  localparam int GOAL_W  = POSITION_BITS + 1;
  localparam int POS_LO  = OPCODE_W;
  localparam int CUR_LO  = OPCODE_W + POSITION_BITS;
  localparam int OUT_USE = 2 * DRIVE_W + MODE_W;

  // Configuration registers
  cfg_regs_t cfg_r;

  // Input stage
  logic                     s1_valid_r;
  logic [OPCODE_W-1:0]      op_r;
  logic [POSITION_BITS-1:0] pos_r;
  logic [CURRENT_BITS-1:0]  cur_r;

  // Persistent tick state
  ctrl_state_t              state_r;
  ctrl_state_t              state_nxt;
  logic [GOAL_W-1:0]        goal_r;
  logic [GOAL_W-1:0]        goal_nxt;

  // Result stage
  logic                     out_valid_r;
  logic [23:0]              out_data_r;

  logic [DRIVE_W-1:0]       drive_up;
  logic [DRIVE_W-1:0]       drive_down;
  logic                     s1_advance;

  // Stage 1 moves on when the result register is free or being drained
  assign s1_advance = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_advance;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pinch_limit <= RST_PINCH_LIMIT;
      cfg_r.debounce    <= RST_DEBOUNCE;
      cfg_r.rev_travel  <= RST_REV_TRAVEL;
      cfg_r.soft_zone   <= RST_SOFT_ZONE;
      cfg_r.open_limit  <= RST_OPEN_LIMIT;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PINCH_LIMIT: cfg_r.pinch_limit <= cfg_data[LIMIT_W-1:0];
        REG_DEBOUNCE:    cfg_r.debounce    <= cfg_data[DEB_W-1:0];
        REG_REV_TRAVEL:  cfg_r.rev_travel  <= cfg_data[TRAVEL_W-1:0];
        REG_SOFT_ZONE:   cfg_r.soft_zone   <= cfg_data[ZONE_W-1:0];
        REG_OPEN_LIMIT:  cfg_r.open_limit  <= cfg_data[ZONE_W-1:0];
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  // Input register: control resets, payload does not
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r  <= in_tdata[OPCODE_W-1:0];
      pos_r <= in_tdata[CUR_LO-1:POS_LO];
      cur_r <= in_tdata[CUR_LO+CURRENT_BITS-1:CUR_LO];
    end
  end

  wapc_step #(
    .POSITION_BITS (POSITION_BITS),
    .CURRENT_BITS  (CURRENT_BITS)
  ) u_step (
    .cfg        (cfg_r),
    .opcode     (op_r),
    .position   (pos_r),
    .motor_cur  (cur_r),
    .state      (state_r),
    .goal       (goal_r),
    .state_nxt  (state_nxt),
    .goal_nxt   (goal_nxt),
    .drive_up   (drive_up),
    .drive_down (drive_down)
  );

  // Mode state commits only when the request moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode        <= MODE_IDLE;
      state_r.pinch_count <= '0;
      goal_r              <= '0;
    end else if (s1_advance) begin
      state_r <= state_nxt;
      goal_r  <= goal_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_data_r <= {(24 - OUT_USE)'(0), state_nxt.mode, drive_down, drive_up};
    end
  end

  // Motor is never driven both ways in one result
  a_drive_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[6:0] == DRIVE_OFF || out_tdata[13:7] == DRIVE_OFF))
    else $error("drive up and drive down both active");

  // A blocked or idle result never drives the motor
  a_rest_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[16:14] == MODE_BLOCKED || out_tdata[16:14] == MODE_IDLE))
    |-> (out_tdata[13:0] == '0))
    else $error("drive active in a resting mode");

  // Closing drive only appears while the mode is moving up
  a_up_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[6:0] != DRIVE_OFF) |-> (out_tdata[16:14] == MODE_UP))
    else $error("closing drive outside moving up");

  // A full input stage behind a stalled result must hold off new requests
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input accepted while pipeline is full");

endmodule

FILE: test/window_anti_pinch_controller_tb.sv
// Self-checking testbench for window_anti_pinch_controller: directed table, then random
// control ticks shaped by a simple window plant, checked against an in-bench predictor.
// Depends on wapc_pkg and the RTL top level; needs no files or arguments.
module window_anti_pinch_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wapc_pkg::*;

  localparam int POS_W      = 12;
  localparam int CUR_W      = 16;
  localparam int GOAL_W     = POS_W + 1;
  localparam int IN_W       = ((OPCODE_W + POS_W + CUR_W + 7) / 8) * 8;
  localparam int PHASES     = 11;
  localparam int PHASE_TICKS = 140;
  localparam int STALL_LIMIT = 1000;   // cycles with no handshake on any channel

  // Codes 5..7 are not commands; the block must treat them as no command
  localparam logic [2:0] OP_UNUSED7 = 3'd7;

  typedef struct packed {
    logic [DRIVE_W-1:0] up;
    logic [DRIVE_W-1:0] down;
    mode_t              mode;
  } drive_result_t;

  // One directed tick; want is only used when typed is set
  typedef struct packed {
    logic [2:0]       op;
    logic [POS_W-1:0] pos;
    logic [CUR_W-1:0] cur;
    logic             typed;
    drive_result_t    want;
  } stim_row_t;

  localparam drive_result_t OFF_IDLE = '{DRIVE_OFF, DRIVE_OFF, MODE_IDLE};
  localparam drive_result_t OFF_UP   = '{DRIVE_OFF, DRIVE_OFF, MODE_UP};

  // Directed walk with reset register values (limit 8000, debounce 3, travel 60,
  // soft zone 30, open limit 1000).
  localparam stim_row_t DIRECTED [20] = '{
    '{OP_NONE,    12'd0,    16'd0,     1'b1, OFF_IDLE}, // idle right after reset
    '{OP_UNUSED7, 12'd4095, 16'd65535, 1'b1, OFF_IDLE}, // unknown code, field maxima
    '{OP_UP,      12'd500,  16'd0,     1'b1, OFF_UP},   // idle -> up, no drive yet
    '{OP_NONE,    12'd500,  16'd9000,  1'b0, OFF_IDLE}, // over limit, count 1
    '{OP_NONE,    12'd480,  16'd9000,  1'b0, OFF_IDLE}, // count 2
    '{OP_NONE,    12'd460,  16'd9000,  1'b0, OFF_IDLE}, // count 3: pinch, reverse
    '{OP_NONE,    12'd500,  16'd0,     1'b0, OFF_IDLE}, // still short of goal
    '{OP_NONE,    12'd520,  16'd0,     1'b0, OFF_IDLE}, // goal reached: blocked
    '{OP_UP,      12'd520,  16'd0,     1'b0, OFF_IDLE}, // up ignored while blocked
    '{OP_DOWN,    12'd520,  16'd0,     1'b0, OFF_IDLE}, // down frees it
    '{OP_NONE,    12'd600,  16'd65535, 1'b0, OFF_IDLE}, // opening, no pinch check
    '{OP_NONE,    12'd1000, 16'd0,     1'b0, OFF_IDLE}, // open limit: idle
    '{OP_DOWN,    12'd100,  16'd0,     1'b0, OFF_IDLE},
    '{OP_STOP,    12'd100,  16'd0,     1'b0, OFF_IDLE}, // stop while opening
    '{OP_AUTO_UP, 12'd30,   16'd65535, 1'b0, OFF_IDLE},
    '{OP_NONE,    12'd30,   16'd65535, 1'b0, OFF_IDLE}, // inside soft zone: no count
    '{OP_NONE,    12'd31,   16'd65535, 1'b0, OFF_IDLE}, // just outside: count 1
    '{OP_STOP,    12'd31,   16'd8000,  1'b0, OFF_IDLE}, // at limit clears count; stop
    '{OP_UP,      12'd10,   16'd0,     1'b0, OFF_IDLE},
    '{OP_NONE,    12'd0,    16'd0,     1'b0, OFF_IDLE}  // fully closed: idle
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [23:0]           out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  window_anti_pinch_controller #(
    .POSITION_BITS(POS_W),
    .CURRENT_BITS (CUR_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: shadow registers plus the controller's own state
  // ---------------------------------------------------------------------------
  cfg_regs_t         regs;
  mode_t             win_mode;
  logic [DEB_W-1:0]  pinch_hits;
  logic [GOAL_W-1:0] reverse_goal;

  drive_result_t     pending_drive_q [$];  // expected results, oldest first
  drive_result_t     last_drive;           // latest predicted result, steers the plant
  int                glass_pos;            // plant position fed back from the drives
  int                surge_left;           // ticks left in an over-current burst
  int unsigned       fail_count;
  bit                calm;                 // set for the last phase: no idling

  // One control tick of the window controller.
  function automatic drive_result_t advance_window(logic [2:0] op, logic [POS_W-1:0] pos,
                                                   logic [CUR_W-1:0] cur);
    drive_result_t      r;
    logic [DEB_W-1:0]   need;
    logic [GOAL_W:0]    goal_sum;
    r.up   = DRIVE_OFF;
    r.down = DRIVE_OFF;
    need   = (regs.debounce == '0) ? DEB_W'(1) : regs.debounce;
    case (win_mode)
      MODE_IDLE: begin
        if (op == OP_UP || op == OP_AUTO_UP) win_mode = MODE_UP;
        else if (op == OP_DOWN) win_mode = MODE_DOWN;
      end
      MODE_UP: begin
        // debounce: saturate at need, clear in soft zone or when not over limit
        if (pos <= regs.soft_zone) pinch_hits = '0;
        else if (cur > regs.pinch_limit) begin
          if (pinch_hits < need) pinch_hits = pinch_hits + 1'b1;
        end else pinch_hits = '0;
        if (pinch_hits >= need) begin
          goal_sum = {2'b00, pos} + regs.rev_travel;
          // goal holds at its ceiling instead of wrapping
          reverse_goal = goal_sum[GOAL_W] ? '1 : goal_sum[GOAL_W-1:0];
          win_mode = MODE_REVERSE;
          r.down   = DRIVE_ON;
        end else if (pos == '0 || op == OP_STOP) begin
          win_mode = MODE_IDLE;
        end else begin
          r.up = DRIVE_ON;
        end
      end
      MODE_REVERSE: begin
        if ({1'b0, pos} >= reverse_goal) win_mode = MODE_BLOCKED;
        else r.down = DRIVE_ON;
      end
      MODE_DOWN: begin
        if (op == OP_STOP || pos >= regs.open_limit) win_mode = MODE_IDLE;
        else r.down = DRIVE_ON;
      end
      MODE_BLOCKED: begin
        if (op == OP_DOWN) win_mode = MODE_DOWN;
      end
      default: win_mode = MODE_IDLE;
    endcase
    r.mode = win_mode;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Presents one tick request, holds it until taken, then predicts its result.
  // A typed expectation replaces the prediction but the predictor still runs.
  task automatic send_tick(logic [2:0] op, logic [POS_W-1:0] pos, logic [CUR_W-1:0] cur,
                           logic typed, drive_result_t want);
    drive_result_t predicted;
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({cur, pos, op});
    do @(posedge clk); while (!in_tready);
    predicted = advance_window(op, pos, cur);
    pending_drive_q.push_back(typed ? want : predicted);
    last_drive = predicted;
  endtask

  // Builds a tick from a crude window plant so that closing runs, pinches,
  // reversals and blocked windows come up often; about one in ten is noise.
  task automatic random_tick();
    int          r;
    int          lim;
    int          headroom;
    logic [2:0]  op;
    logic [CUR_W-1:0] cur;
    // move the plant the way the last drive pushed it
    if (last_drive.up == DRIVE_ON) glass_pos = glass_pos - int'($urandom_range(0, 60));
    if (last_drive.down == DRIVE_ON) glass_pos = glass_pos + int'($urandom_range(0, 60));
    if ($urandom_range(0, 32) == 0) glass_pos = int'($urandom_range(0, 4095));
    if (glass_pos < 0) glass_pos = 0;
    if (glass_pos > 4095) glass_pos = 4095;

    if ($urandom_range(0, 9) == 0) begin
      send_tick(3'($urandom), POS_W'($urandom), CUR_W'($urandom), 1'b0, OFF_IDLE);
      return;
    end

    r = int'($urandom_range(0, 99));
    case (win_mode)
      MODE_IDLE:
        op = (r < 30) ? OP_UP : (r < 45) ? OP_AUTO_UP : (r < 75) ? OP_DOWN :
             (r < 80) ? OP_STOP : (r < 85) ? 3'($urandom_range(5, 7)) : OP_NONE;
      MODE_UP:
        op = (r < 6) ? OP_STOP : (r < 9) ? OP_DOWN : (r < 12) ? OP_UP : OP_NONE;
      MODE_DOWN:
        op = (r < 5) ? OP_STOP : (r < 8) ? OP_UP : OP_NONE;
      MODE_BLOCKED:
        op = (r < 25) ? OP_DOWN : 3'($urandom_range(0, 7));
      default:
        op = 3'($urandom_range(0, 7));
    endcase

    lim = int'(regs.pinch_limit);
    if (surge_left == 0 && win_mode == MODE_UP && $urandom_range(0, 9) == 0)
      surge_left = int'($urandom_range(1, 18));
    if (surge_left > 0) begin
      surge_left--;
      headroom = 65535 - lim;
      cur = (headroom == 0) ? CUR_W'(lim) :
            CUR_W'(lim + int'($urandom_range(1, (headroom < 4000) ? headroom : 4000)));
    end else begin
      r   = int'($urandom_range(0, 19));
      cur = (r == 0) ? CUR_W'(lim) : (r == 1) ? CUR_W'($urandom) :
            CUR_W'($urandom_range(0, lim));
    end
    send_tick(op, POS_W'(glass_pos), cur, 1'b0, OFF_IDLE);
  endtask

  // Drops valid and waits until every expected result has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_drive_q.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Configuration side: only used while the block is drained
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    // upper data bits beyond each register's width are dropped
    case (idx)
      REG_PINCH_LIMIT: regs.pinch_limit = value[LIMIT_W-1:0];
      REG_DEBOUNCE:    regs.debounce    = value[DEB_W-1:0];
      REG_REV_TRAVEL:  regs.rev_travel  = value[TRAVEL_W-1:0];
      REG_SOFT_ZONE:   regs.soft_zone   = value[ZONE_W-1:0];
      REG_OPEN_LIMIT:  regs.open_limit  = value[ZONE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(logic [15:0] limit, logic [15:0] deb, logic [15:0] travel,
                              logic [15:0] zone, logic [15:0] open_lim);
    write_reg(REG_PINCH_LIMIT, limit);
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_REV_TRAVEL, travel);
    write_reg(REG_SOFT_ZONE, zone);
    write_reg(REG_OPEN_LIMIT, open_lim);
    cfg_valid <= 1'b0;
  endtask

  // Random setting; upper data bits carry junk to exercise the masking.
  task automatic program_random_regs();
    logic [15:0] limit, deb, travel, zone, open_lim;
    limit = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(500, 12000));
    deb            = 16'($urandom);
    deb[3:0]       = 4'($urandom_range(0, 15));
    travel         = 16'($urandom);
    zone           = 16'($urandom);
    zone[11:0]     = 12'($urandom_range(0, 400));
    open_lim       = 16'($urandom);
    open_lim[11:0] = 12'($urandom_range(200, 4095));
    program_regs(limit, deb, travel, zone, open_lim);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_PINCH_LIMIT;
    cfg_data   <= '0;
    regs         = '{RST_PINCH_LIMIT, RST_DEBOUNCE, RST_REV_TRAVEL, RST_SOFT_ZONE,
                     RST_OPEN_LIMIT};
    win_mode     = MODE_IDLE;
    pinch_hits   = '0;
    reverse_goal = '0;
    last_drive   = OFF_IDLE;
    glass_pos    = 500;
    surge_left   = 0;
    fail_count   = 0;
    calm         = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i])
      send_tick(DIRECTED[i].op, DIRECTED[i].pos, DIRECTED[i].cur, DIRECTED[i].typed,
                DIRECTED[i].want);
    drain();

    // Phase 0 keeps the reset values; each phase ends drained so the next
    // register writes land on an idle block.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: ;
        1: program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);            // minima, zero debounce
        2: program_regs(16'd65535, 16'd15, 16'd255, 16'd4095, 16'd4095); // maxima
        3: program_regs(16'd9000, 16'hFFF2, 16'hFFC8, 16'hF064, 16'hF7D0); // junk upper bits
        4: program_regs(16'd1000, 16'd1, 16'd255, 16'd0, 16'd4095);    // hair-trigger pinch
        default: program_random_regs();
      endcase
      if (phase == PHASES - 1) calm = 1'b1;
      repeat (PHASE_TICKS) random_tick();
      drain();
    end

    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure bursts, none in the last phase
  // ---------------------------------------------------------------------------
  initial begin : result_ready
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 15) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  task automatic report_mismatch(string field, int want_val, int got_val);
    fail_count++;
    $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want_val, got_val);
  endtask

  // out_tdata, low bit up: drive_up[6:0], drive_down[13:7], window_mode[16:14]
  always @(posedge clk) begin : result_check
    drive_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_drive_q.size() == 0) begin
        fail_count++;
        $display("%0t ns: unexpected result, expected none, got 0x%06h", $time, out_tdata);
      end else begin
        want = pending_drive_q.pop_front();
        if (out_tdata[6:0] !== want.up)
          report_mismatch("drive_up", int'(want.up), int'(out_tdata[6:0]));
        if (out_tdata[13:7] !== want.down)
          report_mismatch("drive_down", int'(want.down), int'(out_tdata[13:7]));
        if (out_tdata[16:14] !== want.mode)
          report_mismatch("window_mode", int'(want.mode), int'(out_tdata[16:14]));
      end
    end
  end

  // Watchdog: a run with no handshake on any channel for too long is hung
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: timeout, no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
